/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define LSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lss_pkg.sv */
// Package with the types and constants of the LIFO stack with sort.
`timescale 1ns / 1ps

package lss_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned DepthW     = 5;

  localparam logic [1:0] OpPush = 2'd0;
  localparam logic [1:0] OpPop  = 2'd1;
  localparam logic [1:0] OpSort = 2'd2;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DataW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] pop_value;
    logic [1:0]              status;
    logic [DepthW-1:0]       depth_now;
  } out_t;

endpackage

/* rtl/lifo_stack_with_sort.sv */
// Top level of the LIFO stack of signed 32-bit values with in-place sort.
//
// Input channel: in_valid_i / in_stall_o / in_data_i (op and push_value).
// Output channel: out_valid_o / out_stall_i / out_data_o (pop_value, status,
// depth_now). Every input beat gives exactly one output beat.
// The block works on one item at a time and raises in_stall_o from the cycle
// after a beat is taken until its result has been loaded into the output
// register. Push, an empty pop and the unused op code go straight to the
// response state; a pop that returns a value passes first through the pop
// state, which takes the registered read of the stack memory.
// Sort runs an exchange sort through the single read port of the memory with
// one comparator, and goes straight to the response state when fewer than two
// entries are stored.
// For push the result goes from the response state into the output register once the output is free.
// While the receiver stalls, the result holds in the output register and a
// finished item waits in its last state, so nothing is lost or overwritten.
// Reset empties the stack and clears the output valid signal; the memory contents
// are not cleared, since only entries below the fill count are ever used.
`timescale 1ns / 1ps

module lifo_stack_with_sort import lss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPop  = 3'd1;
  localparam logic [2:0] SLdX  = 3'd2;
  localparam logic [2:0] SGetX = 3'd3;
  localparam logic [2:0] SCmp  = 3'd4;
  localparam logic [2:0] SWrX  = 3'd5;
  localparam logic [2:0] SResp = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [CountW-1:0]       x_q, x_d;
  logic [CountW-1:0]       j_q, j_d;
  logic signed [DataW-1:0] cur_q, cur_d;
  logic signed [DataW-1:0] res_value_q, res_value_d;
  logic [1:0]              res_status_q, res_status_d;
  logic                    out_valid_q;
  out_t                    out_data_q;

  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic [DataW-1:0]        ram_wdata;
  logic [AddrW-1:0]        ram_raddr;
  logic [DataW-1:0]        ram_rdata;

  logic [CountW-1:0]       count_dec;
  logic [CountW-1:0]       j_next;
  logic [CountW-1:0]       x_next2;
  logic                    slot_free;

  assign count_dec = count_q - CountW'(1);
  assign j_next    = j_q + CountW'(1);
  assign x_next2   = x_q + CountW'(2);
  assign slot_free = !out_valid_q || !out_stall_i;

  lss_ram #(
    .Width(DataW),
    .Depth(StackDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    x_d          = x_q;
    j_d          = j_q;
    cur_d        = cur_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AddrW-1:0];
    ram_wdata    = in_data_i.push_value;
    ram_raddr    = x_q[AddrW-1:0];

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          res_value_d  = '0;
          res_status_d = StDone;
          state_d      = SResp;
          unique case (in_data_i.op)
            OpPush: begin
              if (count_q == CountW'(StackDepth)) begin
                res_status_d = StFull;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CountW'(1);
              end
            end
            OpPop: begin
              if (count_q == '0) begin
                res_status_d = StEmpty;
              end else begin
                ram_raddr = count_dec[AddrW-1:0];
                count_d   = count_dec;
                state_d   = SPop;
              end
            end
            OpSort: begin
              if (count_q >= CountW'(2)) begin
                x_d     = '0;
                j_d     = CountW'(1);
                state_d = SLdX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SPop: begin
        res_value_d = $signed(ram_rdata);
        state_d     = SResp;
      end
      SLdX: begin
        // The read of the pivot entry is issued here.
        state_d = SGetX;
      end
      SGetX: begin
        cur_d     = $signed(ram_rdata);
        ram_raddr = j_q[AddrW-1:0];
        state_d   = SCmp;
      end
      SCmp: begin
        // The pivot lives in cur_q; each larger pivot swaps with entry j.
        ram_raddr = j_next[AddrW-1:0];
        if (cur_q > $signed(ram_rdata)) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[AddrW-1:0];
          ram_wdata = cur_q;
          cur_d     = $signed(ram_rdata);
        end
        if (j_next < count_q) begin
          j_d = j_next;
        end else begin
          state_d = SWrX;
        end
      end
      SWrX: begin
        ram_we    = 1'b1;
        ram_waddr = x_q[AddrW-1:0];
        ram_wdata = cur_q;
        if (x_next2 < count_q) begin
          x_d     = x_q + CountW'(1);
          j_d     = x_next2;
          state_d = SLdX;
        end else begin
          state_d = SResp;
        end
      end
      SResp: begin
        if (slot_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == SResp && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    j_q          <= j_d;
    cur_q        <= cur_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (state_q == SResp && slot_free) begin
      out_data_q.pop_value <= res_value_q;
      out_data_q.status    <= res_status_q;
      out_data_q.depth_now <= DepthW'(count_q);
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/lss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/lss_checker.sv */
// Port-level checker for the LIFO stack with sort, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lss_checker import lss_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic in_beat;
  logic out_held;
  logic empty_res;
  logic empty_clean;

  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign empty_res   = out_valid_o && out_data_o.status == StEmpty;
  assign empty_clean = out_data_o.depth_now == '0 && out_data_o.pop_value == '0;

  // Once a beat is taken the block shows itself busy with it in the next cycle.
  `LSS_ASSERT_NEXT(a_busy_after_accept, in_beat, in_stall_o, "block not busy after a beat")

  `LSS_ASSERT_NEXT(a_out_valid_holds, out_held, out_valid_o, "output valid dropped in stall")

  `LSS_ASSERT_NEXT(a_out_data_holds, out_held, $stable(out_data_o), "payload changed in stall")

  // A pop on an empty stack reports an empty stack and no value.
  `LSS_ASSERT_IMPL(a_empty_pop_fields, empty_res, empty_clean, "empty pop gave depth or value")

endmodule

bind lifo_stack_with_sort lss_checker u_lss_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the LIFO stack with sort: queued stimulus, predicted results.
`timescale 1ns / 1ps

module tb_top;
  import lss_pkg::*;

  // The package names no code for the spare op; the block treats it as a no-op.
  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned IdlePct = 12;
  localparam int unsigned RandomOps = 550;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  in_t queued_ops[$];
  out_t predicted_results[$];
  logic signed [DataW-1:0] stack_image[StackDepth];
  int unsigned fill_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned random_op_count = 0;
  logic in_beat_taken = 1'b0;

  lifo_stack_with_sort dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one operation to the stack image and returns the result it should give.
  function automatic out_t predict_stack_op(in_t beat);
    out_t res;
    logic signed [DataW-1:0] swap;
    int unsigned lo;
    int unsigned hi;
    res = '0;
    res.status = StDone;
    case (beat.op)
      OpPush: begin
        if (fill_count >= StackDepth) begin
          res.status = StFull;
        end else begin
          stack_image[fill_count] = beat.push_value;
          fill_count++;
        end
      end
      OpPop: begin
        if (fill_count == 0) begin
          res.status = StEmpty;
        end else begin
          fill_count--;
          res.pop_value = stack_image[fill_count];
        end
      end
      OpSort: begin
        for (lo = 0; lo + 1 < fill_count; lo++) begin
          for (hi = lo + 1; hi < fill_count; hi++) begin
            if (stack_image[lo] > stack_image[hi]) begin
              swap = stack_image[lo];
              stack_image[lo] = stack_image[hi];
              stack_image[hi] = swap;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.depth_now = DepthW'(fill_count);
    return res;
  endfunction

  function automatic logic signed [DataW-1:0] draw_value();
    case ($urandom_range(0, 9))
      5, 6: return DataW'($signed($urandom_range(0, 8)) - 4);
      7: return 32'sh7fff_ffff;
      8: return 32'sh8000_0000;
      9: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [1:0] op, logic signed [DataW-1:0] value);
    in_t beat;
    beat.op = op;
    beat.push_value = value;
    queued_ops.push_back(beat);
    random_op_count++;
  endtask

  // Idling stops altogether for a stretch in the middle of the run.
  function automatic logic idle_roll();
    if (cycle_count >= 1000 && cycle_count < 3000) return 1'b0;
    return $urandom_range(0, 99) < IdlePct;
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      // A beat on offer is held until it has been taken.
      if (!in_valid_i || in_beat_taken) begin
        if (queued_ops.size() != 0 && !idle_roll()) begin
          in_valid_i <= 1'b1;
          in_data_i <= queued_ops.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= idle_roll();
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none expected, got %p", $time, out_data_o);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data_o.pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %0d got %0d", $time, want.pop_value,
                     out_data_o.pop_value);
            mismatch_count++;
          end
          if (out_data_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data_o.status);
            mismatch_count++;
          end
          if (out_data_o.depth_now !== want.depth_now) begin
            $display("%0t: depth_now expected %0d got %0d", $time, want.depth_now,
                     out_data_o.depth_now);
            mismatch_count++;
          end
        end
      end
      in_beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) predicted_results.push_back(predict_stack_op(in_data_i));
    end
  end

  initial begin
    int unsigned n;
    int unsigned k;
    // Empty stack corner cases, then a one-entry sort and the signed extremes.
    add_op(OpPop, 32'sd0);
    add_op(OpSort, 32'sd0);
    add_op(OpNone, 32'sh5a5a_a5a5);
    add_op(OpPush, 32'sh7fff_ffff);
    add_op(OpSort, -32'sd1);
    add_op(OpPush, 32'sh8000_0000);
    add_op(OpPush, -32'sd1);
    add_op(OpPush, 32'sd0);
    add_op(OpPush, 32'sd1);
    add_op(OpNone, -32'sd1);
    add_op(OpSort, 32'sd0);
    for (k = 0; k < StackDepth - 5; k++) add_op(OpPush, draw_value());
    add_op(OpPush, 32'sh1234_5678);
    add_op(OpSort, 32'sd0);
    add_op(OpPop, -32'sd1);
    random_op_count = 0;

    while (random_op_count < RandomOps) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // Fill, sort and drain: the pops should come out in descending order.
          n = $urandom_range(1, StackDepth + 2);
          for (k = 0; k < n; k++) add_op(OpPush, draw_value());
          add_op(OpSort, draw_value());
          n = n + $urandom_range(0, 2);
          for (k = 0; k < n; k++) add_op(OpPop, draw_value());
        end
        3, 4, 5: begin
          n = $urandom_range(10, 30);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 99)) inside
              [0:44]: add_op(OpPush, draw_value());
              [45:84]: add_op(OpPop, draw_value());
              [85:94]: add_op(OpSort, draw_value());
              default: add_op(OpNone, draw_value());
            endcase
          end
        end
        6: begin
          for (k = 0; k < StackDepth + 3; k++) add_op(OpPush, draw_value());
          add_op(OpSort, draw_value());
          add_op(OpNone, draw_value());
        end
        default: begin
          n = $urandom_range(3, 12);
          for (k = 0; k < n; k++) add_op(2'($urandom_range(0, 3)), $urandom);
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (queued_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lss_pkg.sv
rtl/lss_ram.sv
rtl/lifo_stack_with_sort.sv
rtl/lss_checker.sv
verif/tb_top.sv
